// File: design/vt4_pkg.sv
// types and constants shared by the vertex transform files
package vt4_pkg;

  localparam int CompBits  = 16;
  localparam int FracBits  = 12;
  localparam int EntryBits = 16;
  localparam int NumComps  = 4;
  localparam int CfgBits   = NumComps * EntryBits;
  localparam int IdxBits   = 2;

  localparam int ProdBits  = EntryBits + CompBits;
  localparam int PairBits  = ProdBits + 1;
  localparam int SumBits   = ProdBits + 2;
  localparam int RndBits   = SumBits + 1;
  localparam int ShBits    = RndBits - FracBits;
  localparam int HalfLsb   = (FracBits > 0) ? (1 << (FracBits - 1)) : 0;

  typedef logic signed [CompBits-1:0]  comp_t;
  typedef logic signed [EntryBits-1:0] entry_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [PairBits-1:0]  pair_t;
  typedef logic signed [SumBits-1:0]   sum_t;
  typedef logic signed [RndBits-1:0]   rnd_t;
  typedef logic signed [ShBits-1:0]    sh_t;
  typedef logic [CfgBits-1:0]          col_t;

  typedef enum logic [IdxBits-1:0] {
    REG_COL0 = 2'd0,
    REG_COL1 = 2'd1,
    REG_COL2 = 2'd2,
    REG_COL3 = 2'd3
  } reg_idx_e;

  // stage load enables for the dot product pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } vt4_adv_t;

  localparam col_t Col0Rst = col_t'(64'h0000_0000_0000_1000);
  localparam col_t Col1Rst = col_t'(64'h0000_0000_1000_0000);
  localparam col_t Col2Rst = col_t'(64'h0000_1000_0000_0000);
  localparam col_t Col3Rst = col_t'(64'h1000_0000_0000_0000);

endpackage

// File: design/vt4_in_if.sv
// vertex input channel
interface vt4_in_if import vt4_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t in_x;
  comp_t in_y;
  comp_t in_z;
  comp_t in_w;
  logic  in_last;

  modport source (output valid, in_x, in_y, in_z, in_w, in_last, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, in_last, output ready);
endinterface

// File: design/vt4_out_if.sv
// transformed vertex output channel
interface vt4_out_if import vt4_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;
  logic  out_last;

  modport source (output valid, out_x, out_y, out_z, out_w, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, out_last, output ready);
endinterface

// File: design/vt4_dot4.sv
// four stage dot product of one matrix row with the vertex, rounded and saturated
module vt4_dot4 import vt4_pkg::*; (
  input  logic                    clk_i,
  input  vt4_adv_t                adv_i,
  input  comp_t  [NumComps-1:0]   comp_i,
  input  entry_t [NumComps-1:0]   entry_i,
  output comp_t                   res_o
);

  localparam sh_t SatHi = sh_t'((1 << (CompBits - 1)) - 1);
  localparam sh_t SatLo = sh_t'(-(1 << (CompBits - 1)));

  prod_t [NumComps-1:0] prod_d, prod_q;
  pair_t [1:0]          pair_d, pair_q;
  sum_t                 sum_d, sum_q;
  rnd_t                 rnd;
  sh_t                  sh;
  comp_t                res_d, res_q;

  // stage 1: products
  always_comb begin
    for (int k = 0; k < NumComps; k++) begin
      prod_d[k] = prod_t'($signed(entry_i[k])) * prod_t'($signed(comp_i[k]));
    end
  end

  // stage 2: pair sums
  always_comb begin
    pair_d[0] = pair_t'($signed(prod_q[0])) + pair_t'($signed(prod_q[1]));
    pair_d[1] = pair_t'($signed(prod_q[2])) + pair_t'($signed(prod_q[3]));
  end

  // stage 3: full sum
  assign sum_d = sum_t'($signed(pair_q[0])) + sum_t'($signed(pair_q[1]));

  // stage 4: round, floor shift, saturate
  always_comb begin
    rnd = rnd_t'(sum_q) + rnd_t'(HalfLsb);
    sh  = sh_t'(rnd >>> FracBits);
    if (sh > SatHi) begin
      res_d = comp_t'(SatHi);
    end else if (sh < SatLo) begin
      res_d = comp_t'(SatLo);
    end else begin
      res_d = comp_t'(sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q <= prod_d;
    end
    if (adv_i.s2) begin
      pair_q <= pair_d;
    end
    if (adv_i.s3) begin
      sum_q <= sum_d;
    end
    if (adv_i.s4) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: design/vertex_transform_4x4_core.sv
// vertex transform top level: column registers, stage control and four row pipelines
//
//   channel   dir  handshake      payload
//   vtx_in    in   valid/ready    in_x in_y in_z in_w in_last
//   vtx_out   out  valid/ready    out_x out_y out_z out_w out_last
//   cfg       in   cfg_we_i       cfg_idx_i cfg_data_i (columns 0..3)
//
// four register stages (multiply, pair add, full add, round and saturate)
// one item per cycle unless vtx_out stalls; valid out comes from the round register
// each stage loads when it is empty or the stage after it moves on
// reset clears stage valid bits and loads the identity matrix
module vertex_transform_4x4_core import vt4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxBits-1:0] cfg_idx_i,
  input  col_t             cfg_data_i,
  vt4_in_if.sink           vtx_in,
  vt4_out_if.source        vtx_out
);

  col_t [NumComps-1:0]  col_q;
  logic [3:0]           vld_q;
  logic [3:0]           last_q;
  logic [3:0]           rdy;
  vt4_adv_t             adv;
  comp_t [NumComps-1:0] comp_in;
  comp_t [NumComps-1:0] res;
  reg_idx_e             cfg_idx;

  assign cfg_idx = reg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q[0] <= Col0Rst;
      col_q[1] <= Col1Rst;
      col_q[2] <= Col2Rst;
      col_q[3] <= Col3Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        REG_COL0: col_q[0] <= cfg_data_i;
        REG_COL1: col_q[1] <= cfg_data_i;
        REG_COL2: col_q[2] <= cfg_data_i;
        REG_COL3: col_q[3] <= cfg_data_i;
        default:  col_q[0] <= col_q[0];
      endcase
    end
  end

  // stage control
  always_comb begin
    rdy[3] = vtx_out.ready || !vld_q[3];
    rdy[2] = rdy[3] || !vld_q[2];
    rdy[1] = rdy[2] || !vld_q[1];
    rdy[0] = rdy[1] || !vld_q[0];
    adv.s1 = rdy[0];
    adv.s2 = rdy[1];
    adv.s3 = rdy[2];
    adv.s4 = rdy[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= vtx_in.valid;
      end
      for (int s = 1; s < 4; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      last_q[0] <= vtx_in.in_last;
    end
    for (int s = 1; s < 4; s++) begin
      if (rdy[s]) begin
        last_q[s] <= last_q[s-1];
      end
    end
  end

  assign comp_in[0] = vtx_in.in_x;
  assign comp_in[1] = vtx_in.in_y;
  assign comp_in[2] = vtx_in.in_z;
  assign comp_in[3] = vtx_in.in_w;

  for (genvar r = 0; r < NumComps; r++) begin : g_row
    entry_t [NumComps-1:0] row_entry;

    for (genvar k = 0; k < NumComps; k++) begin : g_col
      assign row_entry[k] = entry_t'(col_q[k][r*EntryBits +: EntryBits]);
    end

    vt4_dot4 u_dot (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .comp_i  (comp_in),
      .entry_i (row_entry),
      .res_o   (res[r])
    );
  end

  assign vtx_in.ready     = rdy[0];
  assign vtx_out.valid    = vld_q[3];
  assign vtx_out.out_x    = res[0];
  assign vtx_out.out_y    = res[1];
  assign vtx_out.out_z    = res[2];
  assign vtx_out.out_w    = res[3];
  assign vtx_out.out_last = last_q[3];

endmodule
